/* design/dspt_pkg.sv */
// Shared types, constants and state codes for the DAG shortest path block.
package dspt_pkg;

  // Default sizes and field limits.
  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 256;
  localparam int FIELD_VERTICES   = 64;
  localparam logic [6:0] NV_RESET = 7'd64;

  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  // Action codes of an input word.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [5:0]        source_vertex;
    logic [5:0]        target_vertex;
    logic signed [15:0] edge_weight;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         vertex_index;
    logic signed [31:0] distance;
    logic               reached;
    logic               edges_dropped;
    logic               last_result;
  } out_word_t;

  typedef struct packed {
    logic [5:0]         src;
    logic [5:0]         dst;
    logic signed [15:0] weight;
  } edge_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FETCH, S_EDGE, S_UPD, S_POP, S_POPQ, S_POPC, S_ORD, S_OLD
  } state_t;

  typedef enum logic [1:0] {
    PH_REACH, PH_DEG, PH_KAHN
  } phase_t;

endpackage

/* design/dag_shortest_path_topological.sv */
// Single-source shortest paths on a DAG from vertex 0, in Kahn order.
//
// Input channel (in_valid/in_ready/in_data): a load word stores one edge;
// edges beyond capacity or naming a vertex at or above the vertex count
// are dropped and flagged. A run word starts the computation.
// in_ready is high only while the block is idle, so loads go one per cycle.
// A run takes: a sweep over every vertex slot that clears degree and cost
// memories, then reachability passes over the stored edges, repeated until
// a pass adds no vertex, then a degree pass over the edges, then for each
// settled vertex a pop from the ready queue, a cost read and a pass over
// the stored edges, and last a step that leaves the queue.
// Results follow on the output channel (out_valid/out_ready/out_data), one
// word per vertex in index order, while the receiver takes them. A stalled
// receiver holds the output register and the run waits on it. The last
// word carries last_result; the edge store and drop flag are emptied then
// and the block goes idle, with that word still able to wait.
// Reset (rst_n low, synchronous) empties the edge store, clears the drop
// flag and sets the vertex count to 64. The cfg port writes the vertex count.
module dag_shortest_path_topological #(
  parameter int MAX_VERTICES = dspt_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = dspt_pkg::DEF_MAX_EDGES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  dspt_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dspt_pkg::out_word_t out_data
);

  localparam int VDEPTH = (MAX_VERTICES < dspt_pkg::FIELD_VERTICES) ?
                          MAX_VERTICES : dspt_pkg::FIELD_VERTICES;
  localparam int VIW = $clog2(VDEPTH);
  localparam int VCW = $clog2(VDEPTH + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);

  // Registers.
  dspt_pkg::state_t state_r, state_nxt;
  dspt_pkg::phase_t ph_r, ph_nxt;
  logic [6:0]        nv_cfg_r, nv_cfg_nxt;
  logic [ECW-1:0]    ecnt_r, ecnt_nxt;
  logic [ECW-1:0]    idx_r, idx_nxt;
  logic              drop_r, drop_nxt;
  logic              changed_r, changed_nxt;
  logic [VDEPTH-1:0] reach_r, reach_nxt;
  logic [VDEPTH-1:0] settled_r, settled_nxt;
  logic [VDEPTH-1:0] has_cost_r, has_cost_nxt;
  logic [VCW-1:0]    v_r, v_nxt;
  logic [VCW-1:0]    head_r, head_nxt;
  logic [VCW-1:0]    tail_r, tail_nxt;
  logic [VIW-1:0]    u_r, u_nxt;
  logic [VIW-1:0]    t_r, t_nxt;
  logic signed [15:0] w_r, w_nxt;
  logic signed [31:0] du_r, du_nxt;
  logic              out_valid_r, out_valid_nxt;
  dspt_pkg::out_word_t out_data_r, out_data_nxt;

  // Memories and their ports.
  dspt_pkg::edge_t    edge_mem [MAX_EDGES];
  logic signed [31:0] cost_mem [VDEPTH];
  logic [ECW-1:0]     deg_mem  [VDEPTH];
  logic [VIW-1:0]     q_mem    [VDEPTH];

  logic               e_we, e_re;
  logic [EAW-1:0]     e_wa, e_ra;
  dspt_pkg::edge_t    e_wd, e_rd;
  logic               c_we, c_re;
  logic [VIW-1:0]     c_wa, c_ra;
  logic signed [31:0] c_wd, c_rd;
  logic               d_we, d_re;
  logic [VIW-1:0]     d_wa, d_ra;
  logic [ECW-1:0]     d_wd, d_rd;
  logic               q_we, q_re;
  logic [VIW-1:0]     q_wa, q_ra, q_wd, q_rd;

  // Effective vertex count.
  logic [6:0] nv_eff;
  always_comb begin
    if (nv_cfg_r == 7'd0) begin
      nv_eff = 7'd1;
    end else if (nv_cfg_r > 7'(VDEPTH)) begin
      nv_eff = 7'(VDEPTH);
    end else begin
      nv_eff = nv_cfg_r;
    end
  end

  // Helpers on the fetched edge and on the relaxation.
  logic               e_ok;
  logic [VIW-1:0]     e_s, e_t;
  logic signed [32:0] cand;
  logic signed [31:0] cand_sat;
  logic [ECW-1:0]     deg_dec;
  logic               in_ok;

  assign e_ok  = ({1'b0, e_rd.src} < nv_eff) && ({1'b0, e_rd.dst} < nv_eff);
  assign e_s   = e_rd.src[VIW-1:0];
  assign e_t   = e_rd.dst[VIW-1:0];
  assign cand  = {du_r[31], du_r} + 33'(w_r);
  assign deg_dec = (d_rd != '0) ? (d_rd - ECW'(1)) : '0;
  assign in_ok = (ecnt_r < ECW'(MAX_EDGES)) &&
                 ({1'b0, in_data.source_vertex} < nv_eff) &&
                 ({1'b0, in_data.target_vertex} < nv_eff);

  always_comb begin
    if (cand > 33'(dspt_pkg::INT_MAX)) begin
      cand_sat = dspt_pkg::INT_MAX;
    end else if (cand < 33'(dspt_pkg::INT_MIN)) begin
      cand_sat = dspt_pkg::INT_MIN;
    end else begin
      cand_sat = cand[31:0];
    end
  end

  assign in_ready  = (state_r == dspt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state, register updates and memory controls.
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    nv_cfg_nxt    = cfg_we ? cfg_wdata : nv_cfg_r;
    ecnt_nxt      = ecnt_r;
    idx_nxt       = idx_r;
    drop_nxt      = drop_r;
    changed_nxt   = changed_r;
    reach_nxt     = reach_r;
    settled_nxt   = settled_r;
    has_cost_nxt  = has_cost_r;
    v_nxt         = v_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    u_nxt         = u_r;
    t_nxt         = t_r;
    w_nxt         = w_r;
    du_nxt        = du_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    e_we = 1'b0; e_re = 1'b0; e_wa = ecnt_r[EAW-1:0]; e_ra = idx_r[EAW-1:0];
    e_wd = '{src: in_data.source_vertex, dst: in_data.target_vertex,
             weight: in_data.edge_weight};
    c_we = 1'b0; c_re = 1'b0; c_wa = t_r; c_ra = e_t; c_wd = cand_sat;
    d_we = 1'b0; d_re = 1'b0; d_wa = t_r; d_ra = e_t; d_wd = deg_dec;
    q_we = 1'b0; q_re = 1'b0; q_wa = tail_r[VIW-1:0]; q_ra = head_r[VIW-1:0];
    q_wd = t_r;

    case (state_r)
      dspt_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.action == dspt_pkg::ACT_RUN) begin
            v_nxt        = '0;
            reach_nxt    = VDEPTH'(1);
            settled_nxt  = '0;
            has_cost_nxt = '0;
            state_nxt    = dspt_pkg::S_CLEAR;
          end else if (in_ok) begin
            e_we     = 1'b1;
            ecnt_nxt = ecnt_r + ECW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end

      // Zero degrees and costs; vertex 0 keeps cost 0.
      dspt_pkg::S_CLEAR: begin
        c_we = 1'b1; c_wa = v_r[VIW-1:0]; c_wd = '0;
        d_we = 1'b1; d_wa = v_r[VIW-1:0]; d_wd = '0;
        v_nxt = v_r + VCW'(1);
        if (v_r == VCW'(VDEPTH - 1)) begin
          ph_nxt      = dspt_pkg::PH_REACH;
          idx_nxt     = '0;
          changed_nxt = 1'b0;
          state_nxt   = dspt_pkg::S_FETCH;
        end
      end

      // Issue an edge read, or close the pass.
      dspt_pkg::S_FETCH: begin
        if (idx_r == ecnt_r) begin
          idx_nxt = '0;
          case (ph_r)
            dspt_pkg::PH_REACH: begin
              changed_nxt = 1'b0;
              if (!changed_r) begin
                ph_nxt = dspt_pkg::PH_DEG;
              end
            end
            dspt_pkg::PH_DEG: begin
              ph_nxt          = dspt_pkg::PH_KAHN;
              settled_nxt[0]  = 1'b1;
              has_cost_nxt[0] = 1'b1;
              q_we = 1'b1; q_wa = '0; q_wd = '0;
              head_nxt  = '0;
              tail_nxt  = VCW'(1);
              state_nxt = dspt_pkg::S_POP;
            end
            default: begin
              state_nxt = dspt_pkg::S_POP;
            end
          endcase
        end else begin
          e_re      = 1'b1;
          state_nxt = dspt_pkg::S_EDGE;
        end
      end

      // Look at the fetched edge.
      dspt_pkg::S_EDGE: begin
        t_nxt     = e_t;
        w_nxt     = e_rd.weight;
        idx_nxt   = idx_r + ECW'(1);
        state_nxt = dspt_pkg::S_FETCH;
        case (ph_r)
          dspt_pkg::PH_REACH: begin
            if (e_ok && reach_r[e_s] && !reach_r[e_t]) begin
              reach_nxt[e_t] = 1'b1;
              changed_nxt    = 1'b1;
            end
          end
          dspt_pkg::PH_DEG: begin
            if (e_ok && (e_t != '0) && reach_r[e_s]) begin
              d_re      = 1'b1;
              idx_nxt   = idx_r;
              state_nxt = dspt_pkg::S_UPD;
            end
          end
          default: begin
            if (e_ok && (e_s == u_r) && (e_t != '0) && !settled_r[e_t]) begin
              d_re      = 1'b1;
              c_re      = 1'b1;
              idx_nxt   = idx_r;
              state_nxt = dspt_pkg::S_UPD;
            end
          end
        endcase
      end

      // Write back a degree count, or relax one edge.
      dspt_pkg::S_UPD: begin
        idx_nxt   = idx_r + ECW'(1);
        state_nxt = dspt_pkg::S_FETCH;
        d_we      = 1'b1;
        if (ph_r == dspt_pkg::PH_DEG) begin
          d_wd = d_rd + ECW'(1);
        end else begin
          if (!has_cost_r[t_r] || (cand_sat < c_rd)) begin
            c_we              = 1'b1;
            has_cost_nxt[t_r] = 1'b1;
          end
          if ((deg_dec == '0) && (tail_r < VCW'(VDEPTH))) begin
            settled_nxt[t_r] = 1'b1;
            q_we             = 1'b1;
            tail_nxt         = tail_r + VCW'(1);
          end
        end
      end

      // Take the next ready vertex, or go on to the results.
      dspt_pkg::S_POP: begin
        if (head_r < tail_r) begin
          q_re      = 1'b1;
          head_nxt  = head_r + VCW'(1);
          state_nxt = dspt_pkg::S_POPQ;
        end else begin
          v_nxt     = '0;
          state_nxt = dspt_pkg::S_ORD;
        end
      end

      dspt_pkg::S_POPQ: begin
        u_nxt     = q_rd;
        c_re      = 1'b1;
        c_ra      = q_rd;
        state_nxt = dspt_pkg::S_POPC;
      end

      dspt_pkg::S_POPC: begin
        du_nxt    = c_rd;
        idx_nxt   = '0;
        state_nxt = dspt_pkg::S_FETCH;
      end

      // Read one vertex cost once the output register frees up.
      dspt_pkg::S_ORD: begin
        if (!out_valid_r || out_ready) begin
          c_re      = 1'b1;
          c_ra      = v_r[VIW-1:0];
          state_nxt = dspt_pkg::S_OLD;
        end
      end

      dspt_pkg::S_OLD: begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.vertex_index  = 6'(v_r);
        out_data_nxt.distance      = settled_r[v_r[VIW-1:0]] ? c_rd : -32'sd1;
        out_data_nxt.reached       = settled_r[v_r[VIW-1:0]];
        out_data_nxt.edges_dropped = drop_r;
        out_data_nxt.last_result   = (7'(v_r) + 7'd1 == nv_eff);
        v_nxt = v_r + VCW'(1);
        if (7'(v_r) + 7'd1 == nv_eff) begin
          ecnt_nxt  = '0;
          drop_nxt  = 1'b0;
          state_nxt = dspt_pkg::S_IDLE;
        end else begin
          state_nxt = dspt_pkg::S_ORD;
        end
      end

      default: begin
        state_nxt = dspt_pkg::S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dspt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= dspt_pkg::PH_REACH;
      nv_cfg_r    <= dspt_pkg::NV_RESET;
      ecnt_r      <= '0;
      idx_r       <= '0;
      drop_r      <= 1'b0;
      changed_r   <= 1'b0;
      reach_r     <= '0;
      settled_r   <= '0;
      has_cost_r  <= '0;
      v_r         <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      nv_cfg_r    <= nv_cfg_nxt;
      ecnt_r      <= ecnt_nxt;
      idx_r       <= idx_nxt;
      drop_r      <= drop_nxt;
      changed_r   <= changed_nxt;
      reach_r     <= reach_nxt;
      settled_r   <= settled_nxt;
      has_cost_r  <= has_cost_nxt;
      v_r         <= v_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    t_r        <= t_nxt;
    w_r        <= w_nxt;
    du_r       <= du_nxt;
    out_data_r <= out_data_nxt;
  end

  // Edge store.
  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_wa] <= e_wd;
    end
    if (e_re) begin
      e_rd <= edge_mem[e_ra];
    end
  end

  // Best cost per vertex.
  always_ff @(posedge clk) begin
    if (c_we) begin
      cost_mem[c_wa] <= c_wd;
    end
    if (c_re) begin
      c_rd <= cost_mem[c_ra];
    end
  end

  // In-degree per vertex.
  always_ff @(posedge clk) begin
    if (d_we) begin
      deg_mem[d_wa] <= d_wd;
    end
    if (d_re) begin
      d_rd <= deg_mem[d_ra];
    end
  end

  // Ready queue.
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    if (q_re) begin
      q_rd <= q_mem[q_ra];
    end
  end

  // Checks on the run sequencer.
  a_ecnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= ECW'(MAX_EDGES))
    else $error("edge count above capacity");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dspt_pkg::S_POP) |-> (head_r <= tail_r) && (tail_r <= VCW'(VDEPTH)))
    else $error("ready queue pointers out of order");

  a_root_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dspt_pkg::S_POPQ) |-> settled_r[0] && has_cost_r[0])
    else $error("vertex 0 not settled during Kahn phase");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dspt_pkg::S_OLD && out_data_nxt.last_result) |=>
      (state_r == dspt_pkg::S_IDLE) && (ecnt_r == '0) && !drop_r)
    else $error("run did not empty the edge store after the last word");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == dspt_pkg::S_OLD))
    else $error("output word loaded outside the emit step");

endmodule

/* tb/dag_shortest_path_topological_tb.sv */
// Testbench for the DAG shortest path block: a self-checking scoreboard, directed cases and random traffic.
module dag_shortest_path_topological_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int STORE_DEPTH = 256;

  // Keeps the edge store, drop flag and vertex count and predicts run results.
  class path_scoreboard;
    dspt_pkg::edge_t     edges[$];
    bit                  drop_seen;
    logic [6:0]          vertex_count = dspt_pkg::NV_RESET;
    dspt_pkg::out_word_t pending[$];
    int                  mismatches;
    int                  words_checked;
    int                  runs_seen;
    int                  edges_loaded;

    function int active_vertices();
      if (vertex_count == 0) return 1;
      if (vertex_count > 64) return 64;
      return vertex_count;
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(dspt_pkg::INT_MAX)) return longint'(dspt_pkg::INT_MAX);
      if (v < longint'(dspt_pkg::INT_MIN)) return longint'(dspt_pkg::INT_MIN);
      return v;
    endfunction

    // Note one accepted input word: store or drop an edge, or predict a run.
    function void note_word(dspt_pkg::in_word_t w);
      int nv;
      bit reach[64];
      int degree[64];
      longint cost[64];
      bit costed[64];
      bit done[64];
      int order[$];
      int u;
      bit grew;
      longint cand;
      dspt_pkg::out_word_t r;
      dspt_pkg::edge_t e;
      nv = active_vertices();
      if (w.action == dspt_pkg::ACT_LOAD) begin
        if (edges.size() >= STORE_DEPTH || w.source_vertex >= nv || w.target_vertex >= nv)
          drop_seen = 1;
        else begin
          e = '{w.source_vertex, w.target_vertex, w.edge_weight};
          edges = {edges, e};
          edges_loaded++;
        end
        return;
      end
      runs_seen++;
      foreach (reach[i]) begin
        reach[i] = 0; degree[i] = 0; cost[i] = 0; costed[i] = 0; done[i] = 0;
      end
      // Reachability from vertex 0, repeated until nothing changes.
      reach[0] = 1;
      do begin
        grew = 0;
        foreach (edges[i])
          if (edges[i].src < nv && edges[i].dst < nv && reach[edges[i].src]
              && !reach[edges[i].dst]) begin
            reach[edges[i].dst] = 1;
            grew = 1;
          end
      end while (grew);
      // In-degrees count only edges from reachable sources, not into vertex 0.
      foreach (edges[i])
        if (edges[i].src < nv && edges[i].dst < nv && edges[i].dst != 0
            && reach[edges[i].src])
          degree[edges[i].dst]++;
      // Kahn order settling with relaxation.
      costed[0] = 1;
      done[0] = 1;
      order = {order, 0};
      while (order.size() > 0) begin
        u = order.pop_front();
        foreach (edges[i]) begin
          if (edges[i].src != u || edges[i].dst >= nv || edges[i].dst == 0
              || done[edges[i].dst]) continue;
          cand = clamp32(cost[u] + longint'($signed(edges[i].weight)));
          if (!costed[edges[i].dst] || cand < cost[edges[i].dst]) begin
            cost[edges[i].dst] = cand;
            costed[edges[i].dst] = 1;
          end
          if (degree[edges[i].dst] > 0) degree[edges[i].dst]--;
          if (degree[edges[i].dst] == 0) begin
            done[edges[i].dst] = 1;
            order = {order, int'(edges[i].dst)};
          end
        end
      end
      for (int v = 0; v < nv; v++) begin
        r.vertex_index  = v[5:0];
        r.distance      = done[v] ? cost[v][31:0] : -32'sd1;
        r.reached       = done[v];
        r.edges_dropped = drop_seen;
        r.last_result   = (v + 1 == nv);
        pending = {pending, r};
      end
      edges.delete();
      drop_seen = 0;
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_word(dspt_pkg::out_word_t got);
      dspt_pkg::out_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      want = pending.pop_front();
      words_checked++;
      if (got.vertex_index !== want.vertex_index || got.distance !== want.distance
          || got.reached !== want.reached || got.edges_dropped !== want.edges_dropped
          || got.last_result !== want.last_result) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                cfg_we = 0;
  logic [6:0]          cfg_wdata = '0;
  logic                in_valid = 0;
  logic                in_ready;
  dspt_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 0;
  dspt_pkg::out_word_t out_data;

  path_scoreboard paths = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  dag_shortest_path_topological dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Receiver stalls at random and the watchdog counts cycles.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Handshake monitor on both channels.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) paths.note_word(in_data);
      if (out_valid && out_ready) paths.check_word(out_data);
    end
  end

  // Offer one word and hold it until it is accepted.
  task automatic send_word(dspt_pkg::in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_edge(int s, int t, int wt);
    dspt_pkg::in_word_t w;
    w.action = dspt_pkg::ACT_LOAD;
    w.source_vertex = s[5:0];
    w.target_vertex = t[5:0];
    w.edge_weight = wt[15:0];
    send_word(w);
  endtask

  // A run word carries random content in its unused fields.
  task automatic start_run();
    dspt_pkg::in_word_t w;
    w = dspt_pkg::in_word_t'($bits(dspt_pkg::in_word_t)'($urandom()));
    w.action = dspt_pkg::ACT_RUN;
    send_word(w);
  endtask

  // Wait until every result is in and the block has gone idle, then write the count.
  task automatic write_vertices(int v);
    in_valid <= 0;
    @(posedge clk);
    while (paths.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v[6:0];
    @(posedge clk);
    paths.vertex_count = v[6:0];
    cfg_we <= 0;
  endtask

  // One graph: mostly forward edges (a DAG), some noise edges anywhere.
  task automatic random_graph(int n_edges);
    int nv;
    int s;
    int t;
    int wt;
    nv = paths.active_vertices();
    for (int i = 0; i < n_edges; i++) begin
      case ($urandom_range(0, 9))
        0: wt = $urandom_range(0, 1) ? 32767 : -32768;
        1, 2: wt = $urandom_range(0, 65535);
        default: wt = $urandom_range(0, 40) - 20;
      endcase
      if ($urandom_range(0, 9) == 0 || nv < 2) begin
        s = $urandom_range(0, 63);
        t = $urandom_range(0, 63);
        if ($urandom_range(0, 1)) begin
          s = s % nv;
          t = t % nv;
        end
      end else begin
        s = $urandom_range(0, nv - 2);
        t = $urandom_range(s + 1, nv - 1);
        if ($urandom_range(0, 3) == 0) s = 0;
      end
      load_edge(s, t, wt);
    end
    start_run();
  endtask

  initial begin
    int nv;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: weight extremes, edge into vertex 0, self-loop, cycle, far vertex.
    send_idle_pct = 34;
    recv_idle_pct = 75;
    load_edge(0, 1, -32768);
    load_edge(1, 2, 32767);
    load_edge(0, 2, 5);
    load_edge(3, 0, 1);
    load_edge(0, 4, 2);
    load_edge(4, 4, 3);
    load_edge(0, 5, 1);
    load_edge(5, 6, 1);
    load_edge(6, 5, 1);
    load_edge(0, 63, 9);
    load_edge(63, 62, -9);
    start_run();
    // Small count drops out-of-range edges; the flag clears at the run after.
    write_vertices(3);
    load_edge(0, 5, 1);
    load_edge(0, 1, 7);
    start_run();
    start_run();
    // Count 0 acts as 1, count above 64 acts as 64.
    write_vertices(0);
    load_edge(0, 0, 4);
    start_run();
    write_vertices(127);
    load_edge(0, 40, 11);
    load_edge(0, 1, 2);
    // Count lowered after loading hides the far edge.
    write_vertices(10);
    start_run();

    // Random phases with changing idling.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 75 : 0;
      recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 34 : 0;
      if (phase == 1) begin
        // Overfill the edge store once.
        write_vertices(64);
        random_graph(STORE_DEPTH + 4);
      end
      for (int g = 0; g < 8; g++) begin
        case ($urandom_range(0, 7))
          0: nv = 1;
          1: nv = 64;
          2: nv = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
          default: nv = $urandom_range(2, 20);
        endcase
        write_vertices(nv);
        random_graph($urandom_range(0, 12));
      end
    end

    in_valid <= 0;
    @(posedge clk);
    while (paths.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d runs, %0d stored edges and %0d result words checked.",
             paths.runs_seen, paths.edges_loaded, paths.words_checked);
    $display("Vertex counts from 0 to 127, store overflow, cycles and weight extremes.");
    if (paths.mismatches == 0 && paths.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

/* files.f */
design/dspt_pkg.sv
design/dag_shortest_path_topological.sv
tb/dag_shortest_path_topological_tb.sv
